// ===== rtl/core/qlsf_pkg.sv =====
// ----------------------------------------------------------------------------
// qlsf_pkg
// Shared types and constants for the quadratic least-squares fit block.
// ----------------------------------------------------------------------------
package qlsf_pkg;

  localparam int CNT_W          = 5;
  localparam int Z_W            = 14;
  localparam int W_W            = 14;
  localparam int ENT_W          = 64;
  localparam int DW             = 224;
  localparam int FRAC_BITS      = 16;
  localparam int COEF_W         = 48;
  localparam int STEP_W         = 8;
  localparam int MAX_POINTS_DEF = 16;
  localparam logic [CNT_W-1:0] MIN_POINTS_RST = CNT_W'(5);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FEW      = 2'd1,
    STATUS_SINGULAR = 2'd2,
    STATUS_DROPPED  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_PROD,
    OP_ADD,
    OP_MLOAD,
    OP_MSTEP,
    OP_COMB,
    OP_DLOAD,
    OP_DSTEP,
    OP_ROUND,
    OP_FAIL,
    OP_FINISH,
    OP_CLEAR
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_PROD,
    S_ADD,
    S_CHECK,
    S_MLOAD,
    S_MSTEP,
    S_COMB,
    S_DETCHK,
    S_DLOAD,
    S_DSTEP,
    S_ROUND,
    S_FINISH,
    S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t      op;
    logic [1:0]  k;
    logic [1:0]  j;
    logic [1:0]  term;
    logic        mul_last;
    status_t     status;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic too_few;
    logic det_zero;
  } dp_stat_t;

endpackage

// ===== rtl/core/qlsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// qlsf_ctrl
// Sequencer: point accumulation, determinant microprogram, division, result.
// ----------------------------------------------------------------------------
module qlsf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  qlsf_pkg::dp_stat_t stat,
  output qlsf_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import qlsf_pkg::*;

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(ENT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DW - 1);

  state_t            state, state_next;
  logic [1:0]        k, k_next, j, j_next, term, term_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= 2'd0;
      j     <= 2'd0;
      term  <= 2'd0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      j     <= j_next;
      term  <= term_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    k_next       = k;
    j_next       = j;
    term_next    = term;
    cnt_next     = cnt;
    cmd.op       = OP_NONE;
    cmd.k        = k;
    cmd.j        = j;
    cmd.term     = term;
    cmd.mul_last = (cnt == MUL_LAST);
    cmd.status   = STATUS_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op     = OP_SQ;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.op     = OP_PROD;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.op     = OP_ADD;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.last) begin
          state_next = S_IDLE;
        end else if (stat.too_few) begin
          cmd.op     = OP_FAIL;
          cmd.status = STATUS_FEW;
          state_next = S_DONE;
        end else begin
          k_next     = 2'd3;
          j_next     = 2'd0;
          term_next  = 2'd0;
          state_next = S_MLOAD;
        end
      end
      S_MLOAD: begin
        cmd.op     = OP_MLOAD;
        cnt_next   = '0;
        state_next = S_MSTEP;
      end
      S_MSTEP: begin
        cmd.op = OP_MSTEP;
        if (cnt == MUL_LAST) begin
          state_next = S_COMB;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      S_COMB: begin
        cmd.op = OP_COMB;
        if (term != 2'd2) begin
          term_next  = term + 2'd1;
          state_next = S_MLOAD;
        end else if (j != 2'd2) begin
          term_next  = 2'd0;
          j_next     = j + 2'd1;
          state_next = S_MLOAD;
        end else begin
          term_next  = 2'd0;
          j_next     = 2'd0;
          state_next = (k == 2'd3) ? S_DETCHK : S_DLOAD;
        end
      end
      S_DETCHK: begin
        if (stat.det_zero) begin
          cmd.op     = OP_FAIL;
          cmd.status = STATUS_SINGULAR;
          state_next = S_DONE;
        end else begin
          k_next     = 2'd0;
          state_next = S_MLOAD;
        end
      end
      S_DLOAD: begin
        cmd.op     = OP_DLOAD;
        cnt_next   = '0;
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (cnt == DIV_LAST) begin
          state_next = S_ROUND;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      S_ROUND: begin
        cmd.op = OP_ROUND;
        if (k == 2'd2) begin
          state_next = S_FINISH;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_MLOAD;
        end
      end
      S_FINISH: begin
        cmd.op     = OP_FINISH;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.op     = OP_CLEAR;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_SQ))
    else $error("accepted point did not enter accumulation");
  a_mul_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_MSTEP && cnt == MUL_LAST) |=> (state == S_COMB))
    else $error("multiply did not end after the last step");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSTEP && cnt == DIV_LAST) |=> (state == S_ROUND))
    else $error("division did not end after the last step");

endmodule

// ===== rtl/core/qlsf_dp.sv =====
// ----------------------------------------------------------------------------
// qlsf_dp
// Datapath: power sums, bit-serial wide multiplier, restoring divider, results.
// ----------------------------------------------------------------------------
module qlsf_dp #(
  parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  qlsf_pkg::dp_cmd_t                      cmd,
  output qlsf_pkg::dp_stat_t                     stat,
  input  logic signed [qlsf_pkg::Z_W-1:0]        z_pos,
  input  logic        [qlsf_pkg::W_W-1:0]        width,
  input  logic                                   last,
  input  logic                                   cfg_we,
  input  logic        [qlsf_pkg::CNT_W-1:0]      cfg_data,
  output qlsf_pkg::status_t                      status,
  output logic signed [qlsf_pkg::COEF_W-1:0]     coef_const,
  output logic signed [qlsf_pkg::COEF_W-1:0]     coef_linear,
  output logic signed [qlsf_pkg::COEF_W-1:0]     coef_square
);
  import qlsf_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
  localparam logic [ENT_W:0] LIM_POS = (65'd1 << (COEF_W - 1)) - 65'd1;
  localparam logic [ENT_W:0] LIM_NEG = 65'd1 << (COEF_W - 1);

  logic [CNT_W-1:0]        min_points;
  logic signed [Z_W-1:0]   z_in;
  logic [W_W-1:0]          w_in;
  logic                    last_q;
  logic signed [27:0]      z2;
  logic signed [28:0]      w2, w2_h;
  logic signed [41:0]      z3;
  logic signed [55:0]      z4;
  logic signed [42:0]      w2z;
  logic signed [56:0]      w2z2;
  logic [CNT_W-1:0]        point_count;
  logic signed [17:0]      sum_z;
  logic signed [30:0]      sum_z2;
  logic signed [43:0]      sum_z3;
  logic signed [56:0]      sum_z4;
  logic signed [32:0]      sum_w2;
  logic signed [45:0]      sum_w2z;
  logic signed [58:0]      sum_w2z2;
  logic                    dropped_flag;

  logic signed [ENT_W-1:0] s_ent [5];
  logic signed [ENT_W-1:0] t_ent [3];

  logic signed [DW-1:0]    mcand, prod, cross_val, dacc, dacc_next, det_val;
  logic signed [ENT_W-1:0] mplier;
  logic [1:0]              p_col, q_col;

  logic [DW-1:0]           nsh, dmag, rem, dacc_abs;
  logic [ENT_W-1:0]        quo;
  logic                    qovf, qneg, ge, up;
  logic [DW:0]             rs;
  logic [ENT_W:0]          qr, lim, mag, sval;
  logic signed [COEF_W-1:0] coef [3];

  function automatic logic signed [ENT_W-1:0] ent(input logic [1:0] i,
                                                  input logic [1:0] c,
                                                  input logic [1:0] kk);
    logic [2:0] idx;
    idx = {1'b0, i} + {1'b0, c};
    if (c == kk) ent = t_ent[i];
    else ent = s_ent[idx];
  endfunction

  always_comb begin
    s_ent[0] = ENT_W'($signed({1'b0, point_count}));
    s_ent[1] = ENT_W'(sum_z);
    s_ent[2] = ENT_W'(sum_z2);
    s_ent[3] = ENT_W'(sum_z3);
    s_ent[4] = ENT_W'(sum_z4);
    t_ent[0] = ENT_W'(sum_w2);
    t_ent[1] = ENT_W'(sum_w2z);
    t_ent[2] = ENT_W'(sum_w2z2);
  end

  assign p_col = (cmd.j == 2'd0) ? 2'd1 : 2'd0;
  assign q_col = (cmd.j == 2'd2) ? 2'd1 : 2'd2;
  assign w2    = $signed({1'b0, w_in}) * $signed({1'b0, w_in});

  always_comb begin
    logic signed [DW-1:0] base;
    base      = (cmd.j == 2'd0) ? '0 : dacc;
    dacc_next = (cmd.j == 2'd1) ? base - prod : base + prod;
  end

  assign dacc_abs = dacc[DW-1] ? DW'(-dacc) : DW'(dacc);
  assign rs       = {rem, nsh[DW-1]};
  assign ge       = (rs >= {1'b0, dmag});
  assign up       = ({rem, 1'b0} >= {1'b0, dmag});
  assign qr       = {1'b0, quo} + (ENT_W + 1)'(up);
  assign lim      = qneg ? LIM_NEG : LIM_POS;
  assign mag      = (qovf || (qr > lim)) ? lim : qr;
  assign sval     = qneg ? (ENT_W + 1)'(-mag) : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_points <= MIN_POINTS_RST;
    end else if (cfg_we) begin
      min_points <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_CLEAR) begin
      point_count  <= '0;
      sum_z        <= '0;
      sum_z2       <= '0;
      sum_z3       <= '0;
      sum_z4       <= '0;
      sum_w2       <= '0;
      sum_w2z      <= '0;
      sum_w2z2     <= '0;
      dropped_flag <= 1'b0;
    end else if (cmd.op == OP_ADD) begin
      if (point_count < MAX_CNT) begin
        sum_z       <= sum_z + 18'(z_in);
        sum_z2      <= sum_z2 + 31'(z2);
        sum_z3      <= sum_z3 + 44'(z3);
        sum_z4      <= sum_z4 + 57'(z4);
        sum_w2      <= sum_w2 + 33'(w2_h);
        sum_w2z     <= sum_w2z + 46'(w2z);
        sum_w2z2    <= sum_w2z2 + 59'(w2z2);
        point_count <= point_count + CNT_W'(1);
      end else begin
        dropped_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        z_in   <= z_pos;
        w_in   <= width;
        last_q <= last;
      end
      OP_SQ: begin
        z2   <= z_in * z_in;
        w2_h <= w2;
      end
      OP_PROD: begin
        z3   <= z2 * z_in;
        z4   <= z2 * z2;
        w2z  <= w2_h * z_in;
        w2z2 <= w2_h * z2;
      end
      OP_MLOAD: begin
        prod <= '0;
        unique case (cmd.term)
          2'd0: begin
            mcand  <= DW'(ent(2'd1, p_col, cmd.k));
            mplier <= ent(2'd2, q_col, cmd.k);
          end
          2'd1: begin
            mcand  <= DW'(ent(2'd1, q_col, cmd.k));
            mplier <= ent(2'd2, p_col, cmd.k);
          end
          default: begin
            mcand  <= cross_val;
            mplier <= ent(2'd0, cmd.j, cmd.k);
          end
        endcase
      end
      OP_MSTEP: begin
        if (mplier[0]) begin
          prod <= cmd.mul_last ? prod - mcand : prod + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >>> 1;
      end
      OP_COMB: begin
        unique case (cmd.term)
          2'd0: cross_val <= prod;
          2'd1: cross_val <= cross_val - prod;
          default: begin
            dacc <= dacc_next;
            if (cmd.j == 2'd2 && cmd.k == 2'd3) begin
              det_val <= dacc_next;
            end
          end
        endcase
      end
      OP_DLOAD: begin
        nsh  <= dacc_abs << FRAC_BITS;
        dmag <= det_val[DW-1] ? DW'(-det_val) : DW'(det_val);
        rem  <= '0;
        quo  <= '0;
        qovf <= 1'b0;
        qneg <= dacc[DW-1] ^ det_val[DW-1];
      end
      OP_DSTEP: begin
        rem  <= ge ? DW'(rs - {1'b0, dmag}) : rs[DW-1:0];
        quo  <= {quo[ENT_W-2:0], ge};
        qovf <= qovf | quo[ENT_W-1];
        nsh  <= nsh << 1;
      end
      OP_ROUND: begin
        coef[cmd.k] <= sval[COEF_W-1:0];
      end
      OP_FAIL: begin
        status  <= cmd.status;
        coef[0] <= '0;
        coef[1] <= '0;
        coef[2] <= '0;
      end
      OP_FINISH: begin
        status <= dropped_flag ? STATUS_DROPPED : STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  assign stat.last     = last_q;
  assign stat.too_few  = (point_count < min_points);
  assign stat.det_zero = (det_val == '0);
  assign coef_const    = coef[0];
  assign coef_linear   = coef[1];
  assign coef_square   = coef[2];

endmodule

// ===== rtl/core/quadratic_least_squares_fit.sv =====
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit
// Least-squares fit of width^2 = a0 + a1 z + a2 z^2 over a set of points.
// ----------------------------------------------------------------------------
// A point transfers when start is high and busy is low; busy then stays high
// while the power products pass a two-stage multiplier pipeline into the
// sums. On a point with last set the block solves the normal equations by
// Cramer's rule: four determinants of nine bit-serial multiplies each, the
// system determinant first, then each numerator determinant and its restoring
// division. Too few points or a zero system determinant end the solve early.
// The result appears for one cycle with done high and must be taken then;
// the sums clear at the same time. min_points may be written at any time
// while busy is low; cfg_ready is always high.
module quadratic_least_squares_fit #(
  parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [qlsf_pkg::Z_W-1:0]     z_pos,
  input  logic        [qlsf_pkg::W_W-1:0]     width,
  input  logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [qlsf_pkg::CNT_W-1:0]   cfg_data,
  output logic                                done,
  output logic        [1:0]                   status,
  output logic signed [qlsf_pkg::COEF_W-1:0]  coef_const,
  output logic signed [qlsf_pkg::COEF_W-1:0]  coef_linear,
  output logic signed [qlsf_pkg::COEF_W-1:0]  coef_square
);
  import qlsf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_t  status_q;

  assign cfg_ready = 1'b1;
  assign status    = status_q;

  qlsf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  qlsf_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .z_pos       (z_pos),
    .width       (width),
    .last        (last),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .status      (status_q),
    .coef_const  (coef_const),
    .coef_linear (coef_linear),
    .coef_square (coef_square)
  );

endmodule

// ===== tb/sv/qlsf_checker.sv =====
// ----------------------------------------------------------------------------
// qlsf_checker
// Watches the point, result and min_points channels of the quadratic fit
// block. It keeps its own copy of the power sums and solves each set with
// wide integer arithmetic. Each result it predicts is queued and then compared
// field by field with the next result the block emits.
// ----------------------------------------------------------------------------
module qlsf_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [qlsf_pkg::Z_W-1:0]     z_pos,
  input  logic        [qlsf_pkg::W_W-1:0]     width,
  input  logic                                last,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic        [qlsf_pkg::CNT_W-1:0]   cfg_data,
  input  logic                                done,
  input  logic        [1:0]                   status,
  input  logic signed [qlsf_pkg::COEF_W-1:0]  coef_const,
  input  logic signed [qlsf_pkg::COEF_W-1:0]  coef_linear,
  input  logic signed [qlsf_pkg::COEF_W-1:0]  coef_square,
  output int                                  fail_count,
  output int                                  fits_pending
);
  import qlsf_pkg::*;

  localparam int MAX_PTS = 16;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    status_t            st;
    logic [COEF_W-1:0]  a0;
    logic [COEF_W-1:0]  a1;
    logic [COEF_W-1:0]  a2;
  } fit_t;

  fit_t fit_q[$];

  logic [CNT_W-1:0]   min_pts;
  logic [CNT_W-1:0]   n_pts;
  logic signed [17:0] acc_z;
  logic signed [30:0] acc_z2;
  logic signed [43:0] acc_z3;
  logic signed [56:0] acc_z4;
  logic signed [32:0] acc_w2;
  logic signed [45:0] acc_w2z;
  logic signed [58:0] acc_w2z2;
  logic               dropped;

  assign fits_pending = fit_q.size();

  function automatic wide_t det3(input wide_t a00, input wide_t a01, input wide_t a02,
                                 input wide_t a10, input wide_t a11, input wide_t a12,
                                 input wide_t a20, input wide_t a21, input wide_t a22);
    return a00 * (a11 * a22 - a12 * a21) - a01 * (a10 * a22 - a12 * a20)
         + a02 * (a10 * a21 - a11 * a20);
  endfunction

  function automatic logic [COEF_W-1:0] scaled_ratio(input wide_t num, input wide_t den);
    logic         neg;
    logic [255:0] nu, du, q, r, lim;
    logic [255:0] res;
    neg = (num < 0) ^ (den < 0);
    nu  = (num < 0) ? -num : num;
    du  = (den < 0) ? -den : den;
    nu  = nu << FRAC_BITS;
    q   = nu / du;
    r   = nu % du;
    if ((r << 1) >= du) q = q + 1;
    lim = neg ? (256'd1 << (COEF_W - 1)) : ((256'd1 << (COEF_W - 1)) - 1);
    if (q > lim) q = lim;
    res = neg ? -q : q;
    return res[COEF_W-1:0];
  endfunction

  function automatic fit_t solve_set();
    fit_t  f;
    wide_t n, s1, s2, s3, s4, t0, t1, t2, d;
    f = '{STATUS_OK, '0, '0, '0};
    n  = wide_t'({1'b0, n_pts});
    s1 = acc_z;   s2 = acc_z2;  s3 = acc_z3;  s4 = acc_z4;
    t0 = acc_w2;  t1 = acc_w2z; t2 = acc_w2z2;
    if (n_pts < min_pts) begin
      f.st = STATUS_FEW;
    end else begin
      d = det3(n, s1, s2, s1, s2, s3, s2, s3, s4);
      if (d == 0) begin
        f.st = STATUS_SINGULAR;
      end else begin
        f.a0 = scaled_ratio(det3(t0, s1, s2, t1, s2, s3, t2, s3, s4), d);
        f.a1 = scaled_ratio(det3(n, t0, s2, s1, t1, s3, s2, t2, s4), d);
        f.a2 = scaled_ratio(det3(n, s1, t0, s1, s2, t1, s2, s3, t2), d);
        f.st = dropped ? STATUS_DROPPED : STATUS_OK;
      end
    end
    return f;
  endfunction

  always @(posedge clk) begin
    fit_t   exp_f;
    longint zl, wl;
    if (rst) begin
      fit_q.delete();
      fail_count = 0;
      min_pts    = MIN_POINTS_RST;
      n_pts      = '0;
      {acc_z, acc_z2, acc_z3, acc_z4, acc_w2, acc_w2z, acc_w2z2} = '0;
      dropped    = 1'b0;
    end else begin
      if (done) begin
        if (fit_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: status=%0d a0=%h a1=%h a2=%h",
                     status, coef_const, coef_linear, coef_square);
        end else begin
          exp_f = fit_q.pop_front();
          if (status != exp_f.st || coef_const != exp_f.a0 ||
              coef_linear != exp_f.a1 || coef_square != exp_f.a2) begin
            fail_count++;
            if (fail_count <= 10)
              $display("fit mismatch: exp st=%0d a0=%h a1=%h a2=%h got st=%0d a0=%h a1=%h a2=%h",
                       exp_f.st, exp_f.a0, exp_f.a1, exp_f.a2,
                       status, coef_const, coef_linear, coef_square);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        min_pts = cfg_data;
      if (start && !busy) begin
        if (n_pts < MAX_PTS) begin
          zl = longint'(z_pos);
          wl = longint'(width);
          acc_z    = acc_z + 18'(zl);
          acc_z2   = acc_z2 + 31'(zl * zl);
          acc_z3   = acc_z3 + 44'(zl * zl * zl);
          acc_z4   = acc_z4 + 57'(zl * zl * zl * zl);
          acc_w2   = acc_w2 + 33'(wl * wl);
          acc_w2z  = acc_w2z + 46'(wl * wl * zl);
          acc_w2z2 = acc_w2z2 + 59'(wl * wl * zl * zl);
          n_pts    = n_pts + 1'b1;
        end else begin
          dropped = 1'b1;
        end
        if (last) begin
          fit_q.push_back(solve_set());
          n_pts   = '0;
          {acc_z, acc_z2, acc_z3, acc_z4, acc_w2, acc_w2z, acc_w2z2} = '0;
          dropped = 1'b0;
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_quadratic_least_squares_fit.sv =====
// ----------------------------------------------------------------------------
// tb_quadratic_least_squares_fit
// Drives point sets into the quadratic fit block: a directed set of extreme,
// singular, short and overlong sets, then random sets under several
// min_points settings and sender idle rates. The checker does the compare.
// ----------------------------------------------------------------------------
module tb_quadratic_least_squares_fit;
  import qlsf_pkg::*;

  localparam int LIMIT = 12000000;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [Z_W-1:0]     z_pos;
  logic        [W_W-1:0]     width;
  logic                      last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic        [CNT_W-1:0]   cfg_data;
  logic                      done;
  logic        [1:0]         status;
  logic signed [COEF_W-1:0]  coef_const;
  logic signed [COEF_W-1:0]  coef_linear;
  logic signed [COEF_W-1:0]  coef_square;
  int                        fail_count;
  int                        fits_pending;
  int                        cycles = 0;
  int                        idle_pct;
  int                        sent;

  quadratic_least_squares_fit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .z_pos(z_pos), .width(width), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status),
    .coef_const(coef_const), .coef_linear(coef_linear), .coef_square(coef_square)
  );

  qlsf_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .z_pos(z_pos), .width(width), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status),
    .coef_const(coef_const), .coef_linear(coef_linear), .coef_square(coef_square),
    .fail_count(fail_count), .fits_pending(fits_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_point(input logic [Z_W-1:0] z, input logic [W_W-1:0] w,
                            input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    z_pos = z;
    width = w;
    last  = lst;
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 1'b0;
    sent++;
  endtask

  task automatic write_min_points(input logic [CNT_W-1:0] v);
    wait (fits_pending == 0);
    repeat (10) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_set();
    int len, mode, k, zr;
    logic [Z_W-1:0] zc;
    logic [W_W-1:0] w;
    k = $urandom_range(99);
    if (k < 8) len = $urandom_range(2, 1);
    else if (k < 18) len = $urandom_range(20, 17);
    else len = $urandom_range(16, 3);
    mode = $urandom_range(9);
    zr   = $urandom_range(3) == 0 ? 8191 : $urandom_range(200, 4);
    zc   = Z_W'($urandom);
    for (int i = 0; i < len; i++) begin
      w = ($urandom_range(1) == 0) ? W_W'($urandom) : W_W'($urandom_range(300));
      if (mode == 0) send_point(zc, w, i == len - 1);
      else if (mode == 1) send_point(Z_W'($urandom), w, i == len - 1);
      else send_point(Z_W'($signed($urandom_range(2 * zr)) - zr), w, i == len - 1);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] cfg_vals[6];
    cfg_vals = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd5, 5'd3};
    rst = 1'b1;
    start = 1'b0;
    z_pos = '0;
    width = '0;
    last = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_pct = 0;
    sent = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    write_min_points(5'd3);
    send_point(-14'sd8191, 14'd0, 1'b0);
    send_point(14'sd8191, 14'd16383, 1'b0);
    send_point(14'sd0, 14'd1, 1'b0);
    send_point(14'sd1, 14'd16383, 1'b0);
    send_point(-14'sd8192, 14'd12345, 1'b1);
    for (int i = 0; i < 3; i++) send_point(14'sd77, 14'd500 + 14'(i), i == 2);
    send_point(14'sd3, 14'd9, 1'b0);
    send_point(-14'sd3, 14'd9, 1'b1);
    for (int i = 0; i < 17; i++)
      send_point(14'(i - 8), 14'(3 * i * i + 2), i == 16);

    for (int ph = 0; ph < 6; ph++) begin
      write_min_points(ph == 5 ? CNT_W'($urandom_range(16, 3)) : cfg_vals[ph]);
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 59 : 27;
      while (sent < 27 + 125 * (ph + 1)) send_random_set();
    end

    wait (fits_pending == 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && fits_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
